[rtl/clrc_pkg.sv]
// Package for the cache line range coalescer.
// Holds table sizes, field widths, operation codes and the internal command type.
// No dependencies.
`timescale 1ns / 1ps

package clrc_pkg;

    // Table and cache geometry.
    localparam int CAPACITY   = 16;
    localparam int LINE_BYTES = 64;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int END_W  = ADDR_W + 1;

    // Table index and fill count widths.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Command queue between the front and back parts (depth is a power of two).
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Masks that clear the byte offset within a line.
    localparam logic [ADDR_W-1:0] LINE_MASK_A = ~ADDR_W'(LINE_BYTES - 1);
    localparam logic [END_W-1:0]  LINE_MASK_E = ~END_W'(LINE_BYTES - 1);

    typedef logic [OP_W-1:0] t_op;

    // Operation codes, also used as command kinds after decoding.
    localparam t_op OP_RECORD = 2'd0;
    localparam t_op OP_DUMP   = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    // Decoded command passed from the front part to the back part.
    typedef struct packed {
        t_op               kind;
        logic [ADDR_W-1:0] lo;
        logic [END_W-1:0]  hi;
    } t_cmd;

    // One stored table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [END_W-1:0]  hi;
    } t_entry;

endpackage

[rtl/clrc_if.sv]
// Handshake interfaces for the request and result channels of the coalescer.
// Depends on clrc_pkg for the field widths.
`timescale 1ns / 1ps

interface clrc_req_if;
    import clrc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;

    modport source (output valid, output operation, output address, output size,
                    input ready);
    modport sink   (input valid, input operation, input address, input size,
                    output ready);
endinterface

interface clrc_res_if;
    import clrc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] range_start;
    logic [END_W-1:0]  range_size;
    logic              entry_valid;
    logic              overflowed;
    logic              last;

    modport source (output valid, output range_start, output range_size,
                    output entry_valid, output overflowed, output last,
                    input ready);
    modport sink   (input valid, input range_start, input range_size,
                    input entry_valid, input overflowed, input last,
                    output ready);
endinterface

[rtl/clrc_front.sv]
// Front part of the coalescer: accepts request items, drops those that do nothing
// and widens record ranges to whole cache lines. Depends on clrc_pkg, clrc_if.
`timescale 1ns / 1ps

module clrc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clrc_req_if.sink      i_req,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output clrc_pkg::t_cmd o_cmd
);
    import clrc_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              w_keep;
    logic              w_accept;
    logic [END_W-1:0]  w_hi_raw;

    // The stage takes a new item when it is empty or its command leaves now.
    assign i_req.ready = !r_valid || i_cmd_ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Exclusive end rounded up to the next line boundary, exact in 33 bits.
    assign w_hi_raw = {1'b0, i_req.address} + END_W'(i_req.size)
                    + END_W'(LINE_BYTES - 1);

    // Classify the item: null ranges and unknown operations cause nothing.
    always_comb begin
        n_cmd.kind = i_req.operation;
        n_cmd.lo   = i_req.address & LINE_MASK_A;
        n_cmd.hi   = w_hi_raw & LINE_MASK_E;
        unique case (i_req.operation)
            OP_RECORD: w_keep = (i_req.address != '0) && (i_req.size != '0);
            OP_DUMP:   w_keep = 1'b1;
            OP_CLEAR:  w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        if (w_accept && w_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Command payload loads only with a kept item.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

[rtl/clrc_queue.sv]
// Short command queue between the front and back parts of the coalescer.
// Depends on clrc_pkg for the command type and queue depth.
`timescale 1ns / 1ps

module clrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  clrc_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output clrc_pkg::t_cmd o_pop_cmd
);
    import clrc_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_fill;
    logic [Q_CNT_W-1:0] n_fill;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_fill != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rptr];

    // Fill level follows pushes and pops.
    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Storage of queued commands.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue fill level beyond its depth");

endmodule

[rtl/clrc_back.sv]
// Back part of the coalescer: holds the range table, scans it for records,
// lists it for dumps and drives the result register. Depends on clrc_pkg, clrc_if.
`timescale 1ns / 1ps

module clrc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  clrc_pkg::t_cmd i_cmd,
    clrc_res_if.source     o_res
);
    import clrc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    // Range table memory with a registered read port.
    t_entry             r_mem [CAPACITY];
    t_entry             r_rdata;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [IDX_W-1:0]   r_cidx;
    logic [IDX_W-1:0]   n_cidx;
    logic [IDX_W-1:0]   w_cidx_inc;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;
    logic [ADDR_W-1:0]  r_lo;
    logic [END_W-1:0]   r_hi;

    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_out_free;
    logic               w_out_load;
    logic [ADDR_W-1:0]  w_out_start;
    logic [END_W-1:0]   w_out_size;
    logic               w_out_entry;
    logic               w_out_ovf;
    logic               w_out_last;
    logic [ADDR_W-1:0]  r_out_start;
    logic [END_W-1:0]   r_out_size;
    logic               r_out_entry;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               w_pop;
    logic               w_is_last;
    logic               w_hit;
    logic [END_W-1:0]   w_lo_ext;
    logic [END_W-1:0]   w_es_ext;
    t_entry             w_merged;

    assign w_out_free = !r_out_valid || o_res.ready;

    // A dump command waits for room in the result register; others go at once.
    assign o_cmd_ready = (r_state == ST_IDLE) && ((i_cmd.kind != OP_DUMP) || w_out_free);
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    // Overlap or touch test and the widened entry for the scanned position.
    assign w_lo_ext   = {1'b0, r_lo};
    assign w_es_ext   = {1'b0, r_rdata.lo};
    assign w_hit      = (w_lo_ext <= r_rdata.hi) && (r_hi >= w_es_ext);
    assign w_merged.lo = (r_lo < r_rdata.lo) ? r_lo : r_rdata.lo;
    assign w_merged.hi = (r_hi > r_rdata.hi) ? r_hi : r_rdata.hi;

    assign w_cidx_inc = r_cidx + 1'b1;
    assign w_is_last  = ({{(CNT_W - IDX_W){1'b0}}, r_cidx} + CNT_W'(1)) == r_count;

    // Sequencer for record scans and dumps.
    always_comb begin
        n_state     = r_state;
        n_cidx      = r_cidx;
        n_count     = r_count;
        n_ovf       = r_ovf;
        w_raddr     = '0;
        w_we        = 1'b0;
        w_waddr     = r_cidx;
        w_wdata     = w_merged;
        w_out_load  = 1'b0;
        w_out_start = r_rdata.lo;
        w_out_size  = r_rdata.hi - w_es_ext;
        w_out_entry = 1'b1;
        w_out_ovf   = 1'b0;
        w_out_last  = w_is_last;
        unique case (r_state)
            ST_IDLE: begin
                n_cidx = '0;
                if (w_pop) begin
                    case (i_cmd.kind)
                        OP_RECORD: begin
                            if (!r_ovf) begin
                                if (r_count == '0) begin
                                    // Empty table: the range becomes the first entry.
                                    w_we       = 1'b1;
                                    w_waddr    = '0;
                                    w_wdata.lo = i_cmd.lo;
                                    w_wdata.hi = i_cmd.hi;
                                    n_count    = CNT_W'(1);
                                end else begin
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (r_ovf || (r_count == '0)) begin
                                // Single result: overflow notice or empty table.
                                w_out_load  = 1'b1;
                                w_out_start = '0;
                                w_out_size  = '0;
                                w_out_entry = 1'b0;
                                w_out_ovf   = r_ovf;
                                w_out_last  = 1'b1;
                            end else begin
                                n_state = ST_DUMP;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_raddr = w_cidx_inc;
                if (w_hit) begin
                    // First touching entry grows to cover the range.
                    w_we    = 1'b1;
                    n_state = ST_IDLE;
                end else if (w_is_last) begin
                    n_state = ST_IDLE;
                    if (r_count == CNT_W'(CAPACITY)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_we       = 1'b1;
                        w_waddr    = r_count[IDX_W-1:0];
                        w_wdata.lo = r_lo;
                        w_wdata.hi = r_hi;
                        n_count    = r_count + 1'b1;
                    end
                end else begin
                    n_cidx = w_cidx_inc;
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_raddr    = w_cidx_inc;
                    n_cidx     = w_cidx_inc;
                    if (w_is_last) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    // Hold the read data while the receiver stalls.
                    w_raddr = r_cidx;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cidx      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cidx      <= n_cidx;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Range under test during a scan.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_lo <= i_cmd.lo;
            r_hi <= i_cmd.hi;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_start <= w_out_start;
            r_out_size  <= w_out_size;
            r_out_entry <= w_out_entry;
            r_out_ovf   <= w_out_ovf;
            r_out_last  <= w_out_last;
        end
    end

    // Table memory: one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.range_start = r_out_start;
    assign o_res.range_size  = r_out_size;
    assign o_res.entry_valid = r_out_entry;
    assign o_res.overflowed  = r_out_ovf;
    assign o_res.last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond table capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(CAPACITY)))
        else $error("overflow flagged while the table has room");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (i_cmd.kind == OP_CLEAR)) |=> ((r_count == '0) && !r_ovf))
        else $error("clear left entries or the overflow flag behind");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) || (r_state == ST_DUMP)) |-> (r_count != '0))
        else $error("table walk with no stored entries");

endmodule

[rtl/cache_line_range_coalescer_top.sv]
// Top level of the cache line range coalescer.
// Depends on clrc_pkg, clrc_if, clrc_front, clrc_queue and clrc_back.
//
// Usage: request items arrive on i_req (operation, address, size) and result
// items leave on o_res, both with a valid/ready handshake. A record item widens
// its range to whole 64-byte lines and merges it into the first stored range it
// overlaps or touches, or appends it, or on a full table sets the overflow flag;
// it gives no result. A clear item empties the table and drops the overflow flag;
// it gives no result. A dump item gives one result per stored range, the last
// one marked, or a single result for an empty or overflowed table.
// An item is first registered in the front stage and then waits in the
// two-entry command queue. A record then tests the stored entries in order
// (up to 16), since the back part reads the table one entry a cycle from
// its single read port; an empty table takes the append at once. A dump
// with stored entries enters the dump state, which loads one result per
// cycle while the receiver does not stall; a single-result dump loads its
// result at once. The back part takes no new item until a scan or dump ends.
// Reset empties the table and clears the overflow flag at once; the table
// memory is not swept. When the receiver stalls, the result register holds and
// the queue lets the front keep taking items until it fills.
`timescale 1ns / 1ps

module cache_line_range_coalescer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clrc_req_if.sink  i_req,
    clrc_res_if.source o_res
);
    import clrc_pkg::*;

    logic w_fc_valid;
    logic w_fc_ready;
    t_cmd w_fc_cmd;
    logic w_qb_valid;
    logic w_qb_ready;
    t_cmd w_qb_cmd;

    // Request decoding and line widening.
    clrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_fc_valid),
        .i_cmd_ready (w_fc_ready),
        .o_cmd       (w_fc_cmd)
    );

    // Decoupling queue.
    clrc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fc_valid),
        .o_push_ready (w_fc_ready),
        .i_push_cmd   (w_fc_cmd),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_cmd    (w_qb_cmd)
    );

    // Table scan, update and dump.
    clrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qb_valid),
        .o_cmd_ready (w_qb_ready),
        .i_cmd       (w_qb_cmd),
        .o_res       (o_res)
    );

endmodule
